### src/mavg_pkg.sv
// Shared constants and types for the six-channel moving-average filter.
package mavg_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int WINDOW_LEN_DEF   = 10;
  localparam int NUM_CHANNELS_DEF = 6;

  // Load enables for the divide stages, one per pipeline stage after the running sum.
  typedef struct packed {
    logic s2;  // magnitude and sign
    logic s3;  // reciprocal product
    logic s4;  // trial quotient times window length
    logic s5;  // corrected, signed result (output register)
  } mavg_stage_en_t;

endpackage

### src/six_channel_moving_average.sv
// Top level of the six-channel moving-average filter: window chain, running sums, divide pipeline.
//
//   channel  direction  handshake                     payload
//   in_      slave      in_tvalid / in_tready         in_tdata: one sample per channel
//   out_     master     out_tvalid / out_tready       out_tdata: one window mean per channel
//
// One word is accepted per cycle unless every stage is full and the output stalls; the rate is
// set by the tap chain, which shifts once per accepted word, and the running sum per channel.
// The divide pipeline behind the sums has one stage per step and a valid bit per stage.
// Reset (rst_n low, synchronous) clears every tap and running sum, so the window holds zeros.
// A stalled output only holds the stages that are full: bubbles collapse, and input keeps
// flowing until every stage holds a word.
module six_channel_moving_average #(
  parameter int WINDOW_LEN   = mavg_pkg::WINDOW_LEN_DEF,
  parameter int NUM_CHANNELS = mavg_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // from bit 0 up: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [mavg_pkg::SAMPLE_W*NUM_CHANNELS-1:0] in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // from bit 0 up: avg_accel_x, avg_accel_y, avg_accel_z, avg_gyro_x, avg_gyro_y, avg_gyro_z
  output logic [mavg_pkg::SAMPLE_W*NUM_CHANNELS-1:0] out_tdata
);

  localparam int SW     = mavg_pkg::SAMPLE_W;
  localparam int DATA_W = SW * NUM_CHANNELS;
  localparam int SUM_W  = SW + $clog2(WINDOW_LEN);

  logic [DATA_W-1:0] tap [WINDOW_LEN];
  logic              in_accept;

  // Stage valids: s1 is the running sum, s5 the output register.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic s1_vld_nxt, s2_vld_nxt, s3_vld_nxt, s4_vld_nxt, out_vld_nxt;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  mavg_pkg::mavg_stage_en_t stage_en;

  // Ready ripples back from the output: a stage loads when it is empty or its successor loads.
  always_comb begin
    rdy5      = !out_vld_r || out_tready;
    rdy4      = !s4_vld_r || rdy5;
    rdy3      = !s3_vld_r || rdy4;
    rdy2      = !s2_vld_r || rdy3;
    rdy1      = !s1_vld_r || rdy2;
    in_accept = in_tvalid && rdy1;
    stage_en.s2 = rdy2;
    stage_en.s3 = rdy3;
    stage_en.s4 = rdy4;
    stage_en.s5 = rdy5;
  end

  always_comb begin
    s1_vld_nxt  = rdy1 ? in_accept : s1_vld_r;
    s2_vld_nxt  = rdy2 ? s1_vld_r  : s2_vld_r;
    s3_vld_nxt  = rdy3 ? s2_vld_r  : s3_vld_r;
    s4_vld_nxt  = rdy4 ? s3_vld_r  : s4_vld_r;
    out_vld_nxt = rdy5 ? s4_vld_r  : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      s3_vld_r  <= s3_vld_nxt;
      s4_vld_r  <= s4_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Window chain: tap 0 takes the new word, the last tap holds the word about to drop out.
  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_tap
    if (k == 0) begin : g_head
      mavg_cell #(.DATA_W(DATA_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_accept),
        .d        (in_tdata),
        .q        (tap[k])
      );
    end else begin : g_body
      mavg_cell #(.DATA_W(DATA_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_accept),
        .d        (tap[k-1]),
        .q        (tap[k])
      );
    end
  end

  logic signed [SUM_W-1:0] sum_r [NUM_CHANNELS];

  // Per channel: add the incoming sample, drop the oldest, then divide.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    logic [SW-1:0]    new_smp;
    logic [SW-1:0]    old_smp;
    logic [SUM_W-1:0] sum_nxt;

    always_comb begin
      new_smp = in_tdata[c*SW +: SW];
      old_smp = tap[WINDOW_LEN-1][c*SW +: SW];
      sum_nxt = sum_r[c]
              + {{(SUM_W-SW){new_smp[SW-1]}}, new_smp}
              - {{(SUM_W-SW){old_smp[SW-1]}}, old_smp};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sum_r[c] <= '0;
      end else if (in_accept) begin
        sum_r[c] <= sum_nxt;
      end
    end

    mavg_div #(.WINDOW_LEN(WINDOW_LEN)) u_div (
      .clk (clk),
      .en  (stage_en),
      .sum (sum_r[c]),
      .avg (out_tdata[c*SW +: SW])
    );
  end

  assign in_tready  = rdy1;
  assign out_tvalid = out_vld_r;

`ifndef SYNTHESIS
  // An accepted word always lands in the running-sum stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_vld_r)
    else $error("accepted word did not reach the running-sum stage");

  // Input only stalls when the sum stage and the stage behind it are both full.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && s2_vld_r))
    else $error("input stalled with a free stage behind it");

  // Reset leaves the window sum cleared and no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (sum_r[0] == '0 && !out_tvalid))
    else $error("reset did not clear the running sum and output");

  // At most five words are in flight.
  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && out_vld_r && !out_tready) |-> !in_tready)
    else $error("input accepted while every stage is full and stalled");
`endif

endmodule

### src/mavg_cell.sv
// One tap of the sample window: holds a word for every channel and passes it on.
module mavg_cell #(
  parameter int DATA_W = mavg_pkg::SAMPLE_W * mavg_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic [DATA_W-1:0] d,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] tap_r;
  logic [DATA_W-1:0] tap_nxt;

  always_comb begin
    tap_nxt = shift_en ? d : tap_r;
  end

  // The window starts cleared, so every tap resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else begin
      tap_r <= tap_nxt;
    end
  end

  assign q = tap_r;

endmodule

### src/mavg_div.sv
// Signed divide of a window sum by the window length, truncating toward zero, in four stages.
module mavg_div #(
  parameter int WINDOW_LEN = mavg_pkg::WINDOW_LEN_DEF
) (
  input  logic                                             clk,
  input  mavg_pkg::mavg_stage_en_t                         en,
  input  logic signed [mavg_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0] sum,
  output logic [mavg_pkg::SAMPLE_W-1:0]                    avg
);

  localparam int SUM_W  = mavg_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
  // One bit more than the magnitude keeps the reciprocal error below a quarter.
  localparam int SHIFT  = SUM_W + 1;
  localparam int PROD_W = SUM_W + SHIFT;
  localparam logic [SHIFT-1:0] RECIP  = SHIFT'((64'd1 << SHIFT) / WINDOW_LEN);
  localparam logic [SUM_W-1:0] WIN_C  = SUM_W'(WINDOW_LEN);

  logic [SUM_W-1:0]     abs2_r, abs2_nxt;
  logic                 neg2_r;
  logic [PROD_W-1:0]    prod3_r, prod3_nxt;
  logic [SUM_W-1:0]     abs3_r;
  logic                 neg3_r;
  logic [SUM_W-1:0]     q0_4_r, q0_4_nxt;
  logic [SUM_W-1:0]     qw4_r, qw4_nxt;
  logic [2*SUM_W-1:0]   qw_full;
  logic [SUM_W-1:0]     abs4_r;
  logic                 neg4_r;
  logic [SUM_W-1:0]     rem;
  logic [SUM_W-1:0]     quot;
  logic [SUM_W-1:0]     res;
  logic [mavg_pkg::SAMPLE_W-1:0] avg_r, avg_nxt;

  always_comb begin
    abs2_nxt  = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
    prod3_nxt = PROD_W'(abs2_r) * PROD_W'(RECIP);
    q0_4_nxt  = prod3_r[PROD_W-1:SHIFT];
    qw_full   = q0_4_nxt * WIN_C;
    qw4_nxt   = qw_full[SUM_W-1:0];
    // Trial quotient is exact or one short; the remainder tells which.
    rem       = abs4_r - qw4_r;
    quot      = (rem >= WIN_C) ? q0_4_r + SUM_W'(1) : q0_4_r;
    res       = neg4_r ? (~quot + SUM_W'(1)) : quot;
    avg_nxt   = res[mavg_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      abs2_r <= abs2_nxt;
      neg2_r <= sum[SUM_W-1];
    end
    if (en.s3) begin
      prod3_r <= prod3_nxt;
      abs3_r  <= abs2_r;
      neg3_r  <= neg2_r;
    end
    if (en.s4) begin
      q0_4_r <= q0_4_nxt;
      qw4_r  <= qw4_nxt;
      abs4_r <= abs3_r;
      neg4_r <= neg3_r;
    end
    if (en.s5) begin
      avg_r <= avg_nxt;
    end
  end

  assign avg = avg_r;

endmodule
